### src/pif_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the polyphase interpolating fir filter
// no dependencies

package pif_pkg;

  // field widths of the transactions
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 8;
  localparam int COEFF_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 2;
  localparam int PROD_W   = SAMPLE_W + COEFF_W;
  localparam int FRAC     = 15;

  // filter geometry, bounded by the coefficient index and phase widths
  localparam int TAPS   = 33;
  localparam int INTERP = 4;

  // command codes of an input transaction
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic coeff_wr;  // write coefficient store
    logic push;      // write delay line, advance write pointer
    logic start;     // latch addresses, clear accumulators
    logic issue;     // read one tap pair
    logic out_load;  // round, saturate, fill output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pipe_busy;  // read or multiply stage still holds a tap
  } ctrl_status_t;

endpackage

### src/pif_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces of the polyphase interpolating fir filter
// depends on pif_pkg

// input channel: load, push or compute transaction
interface pif_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [pif_pkg::CMD_W-1:0]       command;
  logic        [pif_pkg::IDX_W-1:0]       coeff_index;
  logic signed [pif_pkg::COEFF_W-1:0]     coeff_value;
  logic signed [pif_pkg::SAMPLE_W-1:0]    sample_i;
  logic signed [pif_pkg::SAMPLE_W-1:0]    sample_q;
  logic        [pif_pkg::PHASE_W-1:0]     phase;

  modport source (output valid, command, coeff_index, coeff_value, sample_i, sample_q,
                  phase, input ready);
  modport sink   (input valid, command, coeff_index, coeff_value, sample_i, sample_q,
                  phase, output ready);
endinterface

// result channel: one filtered complex sample
interface pif_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pif_pkg::SAMPLE_W-1:0] out_i;
  logic signed [pif_pkg::SAMPLE_W-1:0] out_q;

  modport source (output valid, out_i, out_q, input ready);
  modport sink   (input valid, out_i, out_q, output ready);
endinterface

### src/pif_ctrl.sv
`timescale 1ns / 1ps
// controller of the polyphase interpolating fir filter: handshakes and tap sequencing
// depends on pif_pkg

module pif_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pif_pkg::CMD_W-1:0]     in_command,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pif_pkg::ctrl_cmd_t            cmd,
  input  pif_pkg::ctrl_status_t         status
);

  localparam int TAPS  = pif_pkg::TAPS;
  localparam int PTR_W = $clog2(TAPS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [PTR_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic             out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.coeff_wr = accept && (in_command == pif_pkg::CMD_LOAD);
    cmd.push     = accept && (in_command == pif_pkg::CMD_PUSH);
    cmd.start    = accept && (in_command == pif_pkg::CMD_COMPUTE);
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (cnt_r == PTR_W'(TAPS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + PTR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy && out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/pif_datapath.sv
`timescale 1ns / 1ps
// datapath of the polyphase interpolating fir filter: coefficient store, delay line,
// complex mac pipeline and output rounding; depends on pif_pkg

module pif_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pif_pkg::ctrl_cmd_t                   cmd,
  output pif_pkg::ctrl_status_t                status,
  input  logic        [pif_pkg::IDX_W-1:0]     coeff_index,
  input  logic signed [pif_pkg::COEFF_W-1:0]   coeff_value,
  input  logic signed [pif_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic signed [pif_pkg::SAMPLE_W-1:0]  sample_q,
  input  logic        [pif_pkg::PHASE_W-1:0]   phase,
  output logic signed [pif_pkg::SAMPLE_W-1:0]  out_i,
  output logic signed [pif_pkg::SAMPLE_W-1:0]  out_q
);

  localparam int TAPS    = pif_pkg::TAPS;
  localparam int INTERP  = pif_pkg::INTERP;
  localparam int CDEPTH  = INTERP * TAPS;
  localparam int CADDR_W = $clog2(CDEPTH);
  localparam int PTR_W   = $clog2(TAPS);
  localparam int SW      = pif_pkg::SAMPLE_W;
  localparam int PROD_W  = pif_pkg::PROD_W;
  localparam int ACC_W   = PROD_W + $clog2(TAPS);
  localparam int SH_W    = ACC_W - pif_pkg::FRAC;

  // memories
  logic signed [pif_pkg::COEFF_W-1:0] coeff_mem [CDEPTH];
  logic        [2*SW-1:0]             delay_mem [TAPS];
  logic        [TAPS-1:0]             dl_valid_r;

  // addressing
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   slot_r;
  logic [CADDR_W-1:0] caddr_r;
  logic [31:0]        ph_eff;
  logic [31:0]        base_full;
  logic               idx_ok;

  // pipeline
  logic                               rd_v_r;
  logic                               mul_v_r;
  logic signed [pif_pkg::COEFF_W-1:0] coeff_rd_r;
  logic signed [SW-1:0]               dl_i_r;
  logic signed [SW-1:0]               dl_q_r;
  logic                               dl_ok_r;
  logic signed [PROD_W-1:0]           prod_i_r;
  logic signed [PROD_W-1:0]           prod_q_r;
  logic signed [ACC_W-1:0]            acc_i_r;
  logic signed [ACC_W-1:0]            acc_q_r;
  logic signed [SW-1:0]               out_i_r;
  logic signed [SW-1:0]               out_q_r;

  // round half up, shift out the fraction, saturate to 16 bits
  function automatic logic signed [SW-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [SH_W-1:0]  s;
    t = a + (ACC_W'(1) << (pif_pkg::FRAC - 1));
    s = t[ACC_W-1:pif_pkg::FRAC];
    if (s > $signed(SH_W'(32767))) begin
      round_sat = 16'sh7fff;
    end else if (s < $signed(SH_W'(-32768))) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = SW'(s);
    end
  endfunction

  // bank select: out-of-range phase maps to the last phase
  always_comb begin
    ph_eff    = (32'(phase) >= 32'(INTERP)) ? 32'(INTERP - 1) : 32'(phase);
    base_full = (32'(INTERP - 1) - ph_eff) * 32'(TAPS);
    idx_ok    = (32'(coeff_index) < 32'(CDEPTH));
  end

  // coefficient store
  always_ff @(posedge clk) begin
    if (cmd.coeff_wr && idx_ok) begin
      coeff_mem[CADDR_W'(coeff_index)] <= coeff_value;
    end
    if (cmd.issue) begin
      coeff_rd_r <= coeff_mem[caddr_r];
    end
  end

  // delay line storage
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      delay_mem[wp_r] <= {sample_i, sample_q};
    end
    if (cmd.issue) begin
      {dl_i_r, dl_q_r} <= delay_mem[slot_r];
    end
  end

  // delay line valid bits, pointers and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_valid_r <= '0;
      wp_r       <= '0;
      rd_v_r     <= 1'b0;
      mul_v_r    <= 1'b0;
    end else begin
      rd_v_r  <= cmd.issue;
      mul_v_r <= rd_v_r;
      if (cmd.push) begin
        dl_valid_r[wp_r] <= 1'b1;
        wp_r             <= (wp_r == PTR_W'(TAPS - 1)) ? '0 : wp_r + PTR_W'(1);
      end
    end
  end

  // entry valid flag travels with its read data
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      dl_ok_r <= dl_valid_r[slot_r];
    end
  end

  // tap walk: oldest sample first, taps of the selected bank in order
  always_ff @(posedge clk) begin
    priority if (cmd.start) begin
      slot_r  <= wp_r;
      caddr_r <= CADDR_W'(base_full);
    end else if (cmd.issue) begin
      slot_r  <= (slot_r == PTR_W'(TAPS - 1)) ? '0 : slot_r + PTR_W'(1);
      caddr_r <= caddr_r + CADDR_W'(1);
    end
  end

  // multiply stage, a never-written slot reads as zero
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_i_r <= dl_ok_r ? PROD_W'(dl_i_r * coeff_rd_r) : '0;
      prod_q_r <= dl_ok_r ? PROD_W'(dl_q_r * coeff_rd_r) : '0;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    priority if (cmd.start) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (mul_v_r) begin
      acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
      acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_i_r <= round_sat(acc_i_r);
      out_q_r <= round_sat(acc_q_r);
    end
  end

  assign out_i            = out_i_r;
  assign out_q            = out_q_r;
  assign status.pipe_busy = rd_v_r || mul_v_r;

endmodule

### src/polyphase_interp_fir_top.sv
`timescale 1ns / 1ps
// top level of the polyphase interpolating fir filter
// depends on pif_pkg, pif_if, pif_ctrl and pif_datapath
//
// usage
// - in_ch carries one transaction per valid/ready handshake: command load
//   writes coefficient coeff_index (bank*TAPS+tap) with coeff_value, push
//   writes sample_i/sample_q into the delay line, compute requests one
//   output for phase; command 3 is dropped
// - out_ch carries one out_i/out_q pair for each compute transaction
// - load and push are accepted back to back
// - compute walks the TAPS taps through one shared complex mac, one tap per
//   cycle: read, multiply and accumulate stages, then round and saturate;
//   no new transaction is taken until the result has entered the output
//   register
// - the output register holds a result while out_ch stalls; loads and pushes
//   keep being accepted, a further compute waits before its final stage
// - reset clears the delay line (per-entry valid bits, no clearing pass) and
//   the write pointer; coefficients must be loaded before use

module polyphase_interp_fir_top (
  input logic      clk,
  input logic      rst_n,
  pif_in_if.sink   in_ch,
  pif_out_if.source out_ch
);

  pif_pkg::ctrl_cmd_t    ctrl_cmd;
  pif_pkg::ctrl_status_t dp_status;

  // controller
  pif_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (ctrl_cmd),
    .status     (dp_status)
  );

  // datapath
  pif_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctrl_cmd),
    .status      (dp_status),
    .coeff_index (in_ch.coeff_index),
    .coeff_value (in_ch.coeff_value),
    .sample_i    (in_ch.sample_i),
    .sample_q    (in_ch.sample_q),
    .phase       (in_ch.phase),
    .out_i       (out_ch.out_i),
    .out_q       (out_ch.out_q)
  );

  // a result never overwrites one that has not been taken
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output register overwritten while full");

  // rounding only sees a fully accumulated sum
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.out_load |-> !dp_status.pipe_busy)
    else $error("output loaded with taps still in flight");

  // no memory write while a tap walk reads
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.issue |-> (!ctrl_cmd.push && !ctrl_cmd.coeff_wr))
    else $error("memory write during tap walk");

  // a compute starts its tap walk in the next cycle
  a_start_then_issue: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.start |=> ctrl_cmd.issue)
    else $error("tap walk did not follow compute start");

endmodule
